// ===== rtl/ftnb_pkg.sv =====
// ---------------------------------------------------------------------------
// ftnb_pkg
// Shared types, constants and the cosine-table entry function for the tone/bandpass block.
// ---------------------------------------------------------------------------
`default_nettype none
package ftnb_pkg;

  localparam int SampleRate   = 11025;
  localparam int CosDepth     = 1024;
  localparam int CosIdxW      = 10;
  localparam int Taps         = 8;
  localparam int AmpW         = 15;
  localparam int HzW          = 13;
  localparam int InvGainQ22   = 26963;
  localparam logic [14:0] AmpReset = 15'd8192;

  localparam logic OpTone    = 1'b0;
  localparam logic OpSilence = 1'b1;

  // feedback coefficients, oldest history entry first
  localparam logic signed [31:0] FbCoef [Taps] = '{
    -32'sd673166, 32'sd3952488, -32'sd12726290, 32'sd26527409,
    -32'sd39331858, 32'sd41799285, -32'sd31733558, 32'sd15699073
  };

  // control between the sequencer and the MAC
  typedef struct packed {
    logic clear;
    logic add_ff;
    logic add_fb;
  } mac_ctl_t;

  // Q1.15 cosine of entry idx: quadrant fold plus 8-term Taylor series in Q2.30
  function automatic logic signed [15:0] cos_entry(input logic [CosIdxW-1:0] idx);
    logic [63:0] u, x, x2, term;
    logic signed [63:0] c;
    logic neg;
    u = 64'(idx) * 64'd4;
    neg = 1'b0;
    if (u > 64'(2 * CosDepth)) u = 64'(4 * CosDepth) - u;
    if (u > 64'(CosDepth)) begin
      neg = 1'b1;
      u = 64'(2 * CosDepth) - u;
    end
    x = (u * 64'd1686629713 + 64'(CosDepth / 2)) / 64'(CosDepth);
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    c = signed'(term);
    for (int k = 0; k < 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k + 1) * (2 * k + 2));
      if (k % 2 == 0) c = c - signed'(term);
      else c = c + signed'(term);
    end
    if (c < 0) c = 0;
    c = signed'((unsigned'(c) + 64'd16384) >> 15);
    if (c > 32767) c = 32767;
    return neg ? -16'(c) : 16'(c);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ftnb_serial_mul.sv =====
// ---------------------------------------------------------------------------
// ftnb_serial_mul
// Shift-add signed multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module ftnb_serial_mul import ftnb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic signed [63:0]      p
);
  logic [31:0]        mb;
  logic signed [63:0] ma;
  logic [4:0]         cnt;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ma   <= 64'(a);
        mb   <= b;
        p    <= '0;
      end else if (busy) begin
        // bit 31 of b carries negative weight
        if (mb[0]) p <= (cnt == 5'd31) ? p - ma : p + ma;
        ma  <= ma <<< 1;
        mb  <= mb >> 1;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fm_tone_nco_bandpass.sv =====
// ---------------------------------------------------------------------------
// fm_tone_nco_bandpass
// Phase-accumulator tone source feeding an order-8 Butterworth bandpass IIR.
// ---------------------------------------------------------------------------
// Usage: one input beat per audio sample on s_axis (tdata = operation,
// tone_hz). Operation tone advances the phase by tone_hz*2^32/11025 and feeds
// amp*cos(phase); silence feeds zero and holds the phase. Each beat yields
// exactly one m_axis beat holding the saturated Q1.15 filtered sample.
// The phase increment divide produces one quotient bit per cycle, then
// the cosine lookup runs, and every product goes through one bit-serial
// 32x32 multiplier: amplitude, prescale and eight feedback taps. One beat
// is in the datapath at a time, and a new beat is not taken until the
// current one is written. The output register lets the next beat be
// taken while a result waits; a stalled m_axis holds its result and the
// sequencer waits before writing the next one, which then blocks s_axis.
// cfg writes tone_amplitude (reset 0.25). Reset zeroes phase and the filter
// histories.
// ---------------------------------------------------------------------------
`default_nettype none
module fm_tone_nco_bandpass import ftnb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [0] operation, [13:1] tone_hz
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] filtered_sample
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [14:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_AMP, S_COS, S_COSW, S_AMPW, S_PRE, S_PREW, S_TAP, S_TAPW,
    S_OUT
  } state_t;

  state_t             state;
  logic [14:0]        amp;
  logic [31:0]        phase;
  logic signed [15:0] xh [Taps];
  logic signed [31:0] yh [Taps];
  logic [HzW-1:0]     hz;
  logic [45:0]        rem;
  logic [31:0]        quo;
  logic [5:0]         dcnt;
  logic [2:0]         tap;
  logic signed [63:0] acc;
  logic signed [15:0] xs;
  logic               mstart;
  logic signed [31:0] ma, mbv;
  logic               mdone;
  logic signed [63:0] mp;
  logic signed [63:0] xr;
  logic               out_free;
  logic [14:0]        cos_rom [CosDepth / 4 + 1];
  logic [14:0]        cmag;
  logic [CosIdxW-1:0] cidx, cfold, cqtr;
  logic [CosIdxW-2:0] caddr;
  logic               cneg;

  ftnb_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mbv), .done(mdone), .p(mp)
  );

  // quarter-wave cosine magnitudes
  initial begin
    for (int i = 0; i <= CosDepth / 4; i++) cos_rom[i] = 15'(cos_entry(CosIdxW'(i)));
  end

  always_comb begin
    cidx  = phase[31:32-CosIdxW];
    cfold = (cidx > CosIdxW'(CosDepth / 2)) ? CosIdxW'(CosDepth) - cidx : cidx;
    cneg  = cfold > CosIdxW'(CosDepth / 4);
    cqtr  = cneg ? CosIdxW'(CosDepth / 2) - cfold : cfold;
    caddr = cqtr[CosIdxW-2:0];
  end

  always_ff @(posedge clk) begin
    cmag <= cos_rom[caddr];
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign xr   = (mp + 64'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      amp   <= AmpReset;
      phase <= '0;
      mstart <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < Taps; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else begin
      mstart <= (state == S_COSW) || (state == S_PRE) || (state == S_TAP);
      if (cfg_valid) amp <= cfg_data;
      if (state == S_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          hz  <= s_axis_tdata[13:1];
          // dividend tone_hz*2^32 + SampleRate/2, restoring divide
          rem <= '0;
          quo <= '0;
          dcnt <= '0;
          state <= (s_axis_tdata[0] == OpSilence) ? S_PRE : S_DIV;
          xs <= '0;
          acc <= '0;
        end
        S_DIV: begin
          // shift in dividend bits of {hz, 32'd0}+5512, 45 bits total
          logic [44:0] dvd;
          logic        nb;
          logic [46:0] t;
          dvd = {hz, 32'd0} + 45'(SampleRate / 2);
          nb  = dvd[6'd44 - dcnt];
          t   = {rem, nb} - 47'(SampleRate);
          if (!t[46]) begin
            rem <= t[45:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[44:0], nb};
            quo <= {quo[30:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd44) state <= S_AMP;
        end
        S_AMP: begin
          phase <= phase + quo;
          state <= S_COS;
        end
        S_COS: state <= S_COSW;
        S_COSW: begin
          ma  <= 32'(signed'({1'b0, amp}));
          mbv <= cneg ? -32'(signed'({1'b0, cmag})) : 32'(signed'({1'b0, cmag}));
          state <= S_AMPW;
        end
        S_AMPW: if (mdone) begin
          xs <= 16'(xr);
          state <= S_PRE;
        end
        S_PRE: begin
          ma  <= 32'(xs);
          mbv <= 32'(InvGainQ22);
          state <= S_PREW;
        end
        S_PREW: if (mdone) begin
          logic signed [63:0] xv;
          xv = (xr > 64'sd32767) ? 64'sd32767 : (xr < -64'sd32768 ? -64'sd32768 : xr);
          xs  <= 16'(xv);
          acc <= ((64'(xh[0]) + xv) - 64'sd4 * (64'(xh[2]) + 64'(xh[6]))
                  + 64'sd6 * 64'(xh[4])) <<< 22;
          tap <= '0;
          state <= S_TAP;
        end
        S_TAP: begin
          ma  <= FbCoef[tap];
          mbv <= yh[tap];
          state <= S_TAPW;
        end
        S_TAPW: if (mdone) begin
          acc <= acc + mp;
          if (tap == 3'd7) state <= S_OUT;
          else begin
            tap <= tap + 3'd1;
            state <= S_TAP;
          end
        end
        S_OUT: if (out_free) begin
          logic signed [63:0] y, r;
          y = (acc + 64'sd2097152) >>> 22;
          if (y > 64'sd2147483647) y = 64'sd2147483647;
          if (y < -64'sd2147483648) y = -64'sd2147483648;
          r = (y + 64'sd64) >>> 7;
          if (r > 64'sd32767) r = 64'sd32767;
          if (r < -64'sd32768) r = -64'sd32768;
          for (int i = 0; i < Taps - 1; i++) begin
            xh[i] <= xh[i+1];
            yh[i] <= yh[i+1];
          end
          xh[Taps-1] <= xs;
          yh[Taps-1] <= 32'(y);
          m_axis_tdata <= 16'(r);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_OUT))
    else $error("result without sequencer finish");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready)
    else $error("ready while busy");
endmodule
`default_nettype wire
